// ----- design/fwmi_pkg.sv -----
package fwmi_pkg;

	localparam int DEPTH  = 16;
	localparam int WORD_W = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int IDX_W  = $clog2(DEPTH);

	typedef enum logic [1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_PEEK   = 2'd2,
		CMD_INSERT = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// update request from the command logic to the slot array
	typedef struct packed {
		logic             ins;
		logic             pop;
		logic [IDX_W-1:0] pos;
	} store_ctl_t;

endpackage

// ----- design/fwmi_in_if.sv -----
interface fwmi_in_if import fwmi_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic [1:0]               command;
	logic signed [WORD_W-1:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink (input valid, input command, input value, output ready);

endinterface

// ----- design/fwmi_out_if.sv -----
interface fwmi_out_if import fwmi_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] read_value;
	logic [1:0]               status;
	logic [CNT_W-1:0]         occupancy;

	modport source (output valid, output read_value, output status, output occupancy,
		input ready);
	modport sink (input valid, input read_value, input status, input occupancy,
		output ready);

endinterface

// ----- design/fwmi_store.sv -----
module fwmi_store import fwmi_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  store_ctl_t               ctl,
	input  logic signed [WORD_W-1:0] word,
	output logic signed [WORD_W-1:0] head,
	output logic [CNT_W-1:0]         count
);

	logic signed [WORD_W-1:0] slots_q [DEPTH];
	logic [CNT_W-1:0]         count_q;

	// each slot takes the new word, its lower neighbour or its upper neighbour
	for (genvar i = 0; i < DEPTH; i++) begin : g_slot
		logic signed [WORD_W-1:0] prev_w;
		logic signed [WORD_W-1:0] next_w;

		if (i == 0) begin : g_first
			assign prev_w = word;
		end else begin : g_prev
			assign prev_w = slots_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_w = slots_q[i];
		end else begin : g_next
			assign next_w = slots_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (ctl.ins) begin
				if (IDX_W'(i) == ctl.pos) begin
					slots_q[i] <= word;
				end else if (IDX_W'(i) > ctl.pos) begin
					slots_q[i] <= prev_w;
				end
			end else if (ctl.pop) begin
				slots_q[i] <= next_w;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctl.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign head  = slots_q[0];
	assign count = count_q;

endmodule

// ----- design/fifo_with_middle_insert.sv -----
// path: an accepted item passes through the input register and then the result register,
// where its result can be taken (input register, result register)
// throughput: one item per cycle unless an untaken result stalls it; occupancy and slot array
// update in the cycle an item leaves the input register, so the next sees the new state at once
// reset: arst_n clears the occupancy and all valid flags; slot contents stay undefined
// until written, and no clearing pass is needed
module fifo_with_middle_insert import fwmi_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	fwmi_in_if.sink    req,
	fwmi_out_if.source rsp
);

	// input register
	logic                     valid_s1;
	cmd_t                     cmd_s1;
	logic signed [WORD_W-1:0] value_s1;

	// result register
	logic                     rsp_valid_q;
	logic signed [WORD_W-1:0] read_value_q;
	status_t                  status_q;
	logic [CNT_W-1:0]         occupancy_q;

	// command logic
	logic                     advance;
	logic                     fire;
	logic                     in_ready;
	logic signed [WORD_W-1:0] head;
	logic [CNT_W-1:0]         count;
	logic                     full;
	logic                     empty;
	logic [CNT_W-1:0]         half_plus;
	logic [CNT_W-1:0]         mid_pos;
	store_ctl_t               ctl;
	store_ctl_t               ctl_gated;
	logic signed [WORD_W-1:0] rd_nxt;
	status_t                  st_nxt;
	logic [CNT_W-1:0]         occ_nxt;

	// result slot free or being drained this cycle
	assign advance  = !rsp_valid_q || rsp.ready;
	assign fire     = valid_s1 && advance;
	// the input register may take an item when it is empty or moving on
	assign in_ready = !valid_s1 || advance;
	assign req.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && req.valid) begin
			cmd_s1   <= cmd_t'(req.command);
			value_s1 <= req.value;
		end
	end

	assign full  = (count == CNT_W'(DEPTH));
	assign empty = (count == '0);

	// middle position floor(n/2)+1, pulled back to the tail when past it
	assign half_plus = (count >> 1) + CNT_W'(1);
	assign mid_pos   = (half_plus > count) ? count : half_plus;

	always_comb begin
		ctl     = '0;
		rd_nxt  = '0;
		st_nxt  = ST_OK;
		occ_nxt = count;
		unique case (cmd_s1)
			CMD_PUSH: begin
				if (full) begin
					st_nxt = ST_FULL;
				end else begin
					ctl.ins = 1'b1;
					ctl.pos = count[IDX_W-1:0];
					occ_nxt = count + CNT_W'(1);
				end
			end
			CMD_POP: begin
				if (empty) begin
					st_nxt = ST_EMPTY;
				end else begin
					ctl.pop = 1'b1;
					rd_nxt  = head;
					occ_nxt = count - CNT_W'(1);
				end
			end
			CMD_PEEK: begin
				if (empty) begin
					st_nxt = ST_EMPTY;
				end else begin
					rd_nxt = head;
				end
			end
			CMD_INSERT: begin
				if (full) begin
					st_nxt = ST_FULL;
				end else begin
					// an empty queue takes the word at the head
					ctl.ins = 1'b1;
					ctl.pos = mid_pos[IDX_W-1:0];
					occ_nxt = count + CNT_W'(1);
				end
			end
			default: begin
				st_nxt = ST_OK;
			end
		endcase
	end

	// the slot array only moves when the item really leaves the input register
	assign ctl_gated = fire ? ctl : '0;

	fwmi_store u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl_gated),
		.word  (value_s1),
		.head  (head),
		.count (count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			read_value_q <= rd_nxt;
			status_q     <= st_nxt;
			occupancy_q  <= occ_nxt;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = read_value_q;
	assign rsp.status     = status_q;
	assign rsp.occupancy  = occupancy_q;

endmodule

// ----- design/fwmi_checker.sv -----
module fwmi_checker import fwmi_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     req_ready,
	input logic                     rsp_valid,
	input logic                     rsp_ready,
	input logic signed [WORD_W-1:0] read_value,
	input logic [1:0]               status,
	input logic [CNT_W-1:0]         occupancy
);

	// an empty result slot never holds back the input side
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("input stalled with no result pending");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> occupancy <= CNT_W'(DEPTH))
		else $error("occupancy beyond depth");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EMPTY |-> occupancy == '0 && read_value == '0)
		else $error("empty status with words stored or nonzero value");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> occupancy == CNT_W'(DEPTH) && read_value == '0)
		else $error("full status without a full queue");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_value) && $stable(status)
			&& $stable(occupancy))
		else $error("stalled result changed");

endmodule

bind fifo_with_middle_insert fwmi_checker u_fwmi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.read_value(rsp.read_value),
	.status    (rsp.status),
	.occupancy (rsp.occupancy)
);
